/* src/rsd_pkg.sv */
// Shared types and constants for the date-ordered record sorter.
package rsd_pkg;

  // Default capacity of the record store.
  localparam int unsigned RSD_MAX_RECORDS = 32;

  // Field widths of one record.
  localparam int unsigned RSD_TAG_W   = 16;
  localparam int unsigned RSD_DAY_W   = 5;
  localparam int unsigned RSD_MONTH_W = 4;
  localparam int unsigned RSD_YEAR_W  = 12;
  localparam int unsigned RSD_KEY_W   = RSD_YEAR_W + RSD_MONTH_W + RSD_DAY_W;

  // One stored record.
  typedef struct packed {
    logic [RSD_TAG_W-1:0]   tag;
    logic [RSD_DAY_W-1:0]   day;
    logic [RSD_MONTH_W-1:0] month;
    logic [RSD_YEAR_W-1:0]  year;
  } rsd_rec_t;

  // Sort key: year is most significant, then month, then day.
  function automatic logic [RSD_KEY_W-1:0] rsd_key(input rsd_rec_t r);
    rsd_key = {r.year, r.month, r.day};
  endfunction

endpackage

/* src/rsd_mem.sv */
// Record store: one write port and one registered read port.
module rsd_mem #(
  parameter int unsigned Depth = rsd_pkg::RSD_MAX_RECORDS,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  rsd_pkg::rsd_rec_t wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output rsd_pkg::rsd_rec_t rdata_o
);
  import rsd_pkg::*;

  rsd_rec_t mem_q [Depth];
  rsd_rec_t rdata_q;

  // Write when we_i is high and read every cycle; read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/rsd_cmp.sv */
// Shared key comparator: tells whether the held record must move past another.
module rsd_cmp (
  input  rsd_pkg::rsd_rec_t held_i,
  input  rsd_pkg::rsd_rec_t other_i,
  output logic              swap_o
);
  import rsd_pkg::*;

  // A swap is needed when the held record's date is strictly later.
  assign swap_o = rsd_key(held_i) > rsd_key(other_i);

endmodule

/* src/record_sort_by_date.sv */
// Top level of the date-ordered record sorter with its sequencer.
//
// Usage: present a record on record_tag_i, day_i, month_i and year_i and
// raise start_i; the transaction is taken at a clock edge with busy_o low.
// Records past the store capacity are dropped and the burst then reports
// overflow_o. A record with last_i high ends the set: busy_o rises, the
// stored records are exchange-sorted by (year, month, day) and emitted in
// ascending order, one per cycle, each marked by valid_o for one cycle,
// with out_last_o on the final one.
// Each outer pass fetches the held record (S_RDI, S_RDJ), compares it with
// each remaining entry in S_CMP and writes it back in S_WRI, all through
// the single read port of the store and the one shared comparator.
// The receiver cannot stall; results are shown once and must be taken.
// Reset empties the set and clears the overflow flag; store contents are
// left as they are and never shown with valid_o before they are written.
module record_sort_by_date #(
  parameter int unsigned MAX_RECORDS = rsd_pkg::RSD_MAX_RECORDS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [rsd_pkg::RSD_TAG_W-1:0]   record_tag_i,
  input  logic [rsd_pkg::RSD_DAY_W-1:0]   day_i,
  input  logic [rsd_pkg::RSD_MONTH_W-1:0] month_i,
  input  logic [rsd_pkg::RSD_YEAR_W-1:0]  year_i,
  input  logic                           last_i,
  output logic                           valid_o,
  output logic [rsd_pkg::RSD_TAG_W-1:0]   out_tag_o,
  output logic [rsd_pkg::RSD_DAY_W-1:0]   out_day_o,
  output logic [rsd_pkg::RSD_MONTH_W-1:0] out_month_o,
  output logic [rsd_pkg::RSD_YEAR_W-1:0]  out_year_o,
  output logic                           out_last_o,
  output logic                           overflow_o
);
  import rsd_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_RECORDS);
  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);

  // Sequencer states.
  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_RDI   = 3'd1;
  localparam logic [2:0] S_RDJ   = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_WRI   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            dropped_q, dropped_d;
  logic [IdxW-1:0] i_q, i_d;
  logic [IdxW-1:0] j_q, j_d;
  logic            valid_q, valid_d;
  logic            last_q, last_d;
  rsd_rec_t        held_q, held_d;

  logic            we;
  logic [IdxW-1:0] waddr;
  rsd_rec_t        wdata;
  logic [IdxW-1:0] raddr;
  rsd_rec_t        rdata;
  rsd_rec_t        in_rec;
  logic            swap;
  logic            accept;
  logic            has_room;

  assign in_rec   = '{tag: record_tag_i, day: day_i, month: month_i, year: year_i};
  assign accept   = start_i && (state_q == S_LOAD);
  assign has_room = count_q < CntW'(MAX_RECORDS);

  rsd_mem #(
    .Depth(MAX_RECORDS),
    .AddrW(IdxW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  rsd_cmp u_cmp (
    .held_i (held_q),
    .other_i(rdata),
    .swap_o (swap)
  );

  // Sequencer: load, exchange sort with the outer entry held in a register, emit.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    i_d       = i_q;
    j_d       = j_q;
    held_d    = held_q;
    valid_d   = 1'b0;
    last_d    = last_q;
    we        = 1'b0;
    waddr     = count_q[IdxW-1:0];
    wdata     = in_rec;
    raddr     = i_q;
    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (has_room) begin
            we      = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_i) begin
            i_d     = '0;
            state_d = (count_d == CntW'(1)) ? S_EMIT : S_RDI;
          end
        end
      end
      S_RDI: begin
        raddr   = i_q;
        j_d     = i_q + IdxW'(1);
        state_d = S_RDJ;
      end
      S_RDJ: begin
        held_d  = rdata;
        raddr   = j_q;
        state_d = S_CMP;
      end
      S_CMP: begin
        // Compare against entry j; on a swap the held record goes to j.
        if (swap) begin
          we     = 1'b1;
          waddr  = j_q;
          wdata  = held_q;
          held_d = rdata;
        end
        raddr = j_q + IdxW'(1);
        if (CntW'(j_q) + CntW'(1) == count_q) begin
          state_d = S_WRI;
        end else begin
          j_d = j_q + IdxW'(1);
        end
      end
      S_WRI: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = held_q;
        if (CntW'(i_q) + CntW'(2) == count_q) begin
          i_d     = '0;
          state_d = S_EMIT;
        end else begin
          i_d     = i_q + IdxW'(1);
          state_d = S_RDI;
        end
      end
      S_EMIT: begin
        // Issue one read a cycle; the registered result shows in the cycle after.
        raddr   = i_q;
        valid_d = 1'b1;
        last_d  = (CntW'(i_q) + CntW'(1) == count_q);
        if (last_d) begin
          state_d = S_DRAIN;
        end else begin
          i_d = i_q + IdxW'(1);
        end
      end
      S_DRAIN: begin
        count_d   = '0;
        dropped_d = 1'b0;
        state_d   = S_LOAD;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      valid_q   <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      i_q       <= i_d;
      j_q       <= j_d;
      valid_q   <= valid_d;
      last_q    <= last_d;
    end
  end

  // Held record of the outer loop.
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  assign busy_o      = (state_q != S_LOAD);
  assign valid_o     = valid_q;
  assign out_tag_o   = rdata.tag;
  assign out_day_o   = rdata.day;
  assign out_month_o = rdata.month;
  assign out_year_o  = rdata.year;
  assign out_last_o  = last_q;
  assign overflow_o  = dropped_q;

endmodule

/* src/rsd_checker.sv */
// Port-level checks of the record sorter and the bind that attaches them.
module rsd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic last_i,
  input logic valid_o,
  input logic out_last_o,
  input logic overflow_o
);

  // Results only come out while the block is busy.
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result shown while not busy");

  // A burst has no gaps until its final result.
  a_burst_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !out_last_o |=> valid_o)
    else $error("gap inside result burst");

  // After the final result the block is free for a new set.
  a_burst_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_last_o |=> !valid_o && !busy_o)
    else $error("block not free after final result");

  // A record without the last mark leaves the block free for the next record.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !last_i |=> !busy_o)
    else $error("busy after an unmarked record");

  // The overflow flag is the same on every result of a burst.
  a_ovf_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(valid_o) |-> $stable(overflow_o))
    else $error("overflow flag changed inside burst");

endmodule

bind record_sort_by_date rsd_checker u_rsd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .last_i    (last_i),
  .valid_o   (valid_o),
  .out_last_o(out_last_o),
  .overflow_o(overflow_o)
);
